/* src/clbw_pkg.sv */
// Shared types, codes and the sequencer program of the character LCD bus writer.
`default_nettype none

package clbw_pkg;

    localparam int NumDigits   = 5;
    localparam int DigitIdxW   = 3;
    localparam int DivRecip    = 52429;
    localparam int DivShift    = 19;
    localparam logic [7:0] AsciiZero = 8'd48;
    localparam logic [7:0] LastColumn = 8'd16;

    typedef enum logic [1:0] {
        MODE_CMD    = 2'd0,
        MODE_DATA   = 2'd1,
        MODE_CURSOR = 2'd2,
        MODE_NUMBER = 2'd3
    } clbw_mode_t;

    typedef enum logic [1:0] {
        CFG_NIBBLE_MODE = 2'd0,
        CFG_ROW_ONE     = 2'd1,
        CFG_ROW_TWO     = 2'd2,
        CFG_NONE        = 2'd3
    } clbw_cfg_idx_t;

    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  byte_value;
        logic [7:0]  row;
        logic [7:0]  column;
        logic [15:0] number;
    } clbw_in_t;

    typedef struct packed {
        logic       reg_select;
        logic [7:0] bus_value;
        logic       last;
    } clbw_out_t;

    typedef struct packed {
        logic [1:0] index;
        logic [7:0] value;
    } clbw_cfg_t;

    typedef enum logic [2:0] {
        ST_WAIT    = 3'd0,
        ST_DIV     = 3'd1,
        ST_PICK    = 3'd2,
        ST_EMIT_HI = 3'd3,
        ST_EMIT_LO = 3'd4,
        ST_TEST    = 3'd5,
        ST_BYTE    = 3'd6,
        ST_CURSOR  = 3'd7
    } clbw_step_t;

    typedef enum logic [2:0] {
        OP_WAIT,
        OP_DIV,
        OP_PICK,
        OP_EMIT_HI,
        OP_EMIT_LO,
        OP_NOP,
        OP_BYTE,
        OP_CURSOR
    } clbw_op_t;

    typedef enum logic [2:0] {
        C_NEXT,
        C_ALWAYS,
        C_DISPATCH,
        C_DIV_MORE,
        C_EIGHT_BIT,
        C_DIGITS_LEFT
    } clbw_cond_t;

    typedef struct packed {
        clbw_op_t   op;
        clbw_cond_t cond;
        clbw_step_t target;
    } clbw_uword_t;

    // One word per step; untaken jumps fall through, save at EMIT_LO and TEST.
    function automatic clbw_uword_t ucode(clbw_step_t step);
        clbw_uword_t w;
        unique case (step)
            ST_WAIT:    w = '{OP_WAIT,    C_DISPATCH,    ST_WAIT};
            ST_DIV:     w = '{OP_DIV,     C_DIV_MORE,    ST_DIV};
            ST_PICK:    w = '{OP_PICK,    C_NEXT,        ST_WAIT};
            ST_EMIT_HI: w = '{OP_EMIT_HI, C_EIGHT_BIT,   ST_TEST};
            ST_EMIT_LO: w = '{OP_EMIT_LO, C_NEXT,        ST_WAIT};
            ST_TEST:    w = '{OP_NOP,     C_DIGITS_LEFT, ST_PICK};
            ST_BYTE:    w = '{OP_BYTE,    C_ALWAYS,      ST_EMIT_HI};
            ST_CURSOR:  w = '{OP_CURSOR,  C_ALWAYS,      ST_EMIT_HI};
            default:    w = '{OP_WAIT,    C_DISPATCH,    ST_WAIT};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

/* src/clbw_stream_if.sv */
// Valid/ready channel carrying one payload struct.
`default_nettype none

interface clbw_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* src/char_lcd_bus_writer.sv */
// Top level: microcoded sequencer that turns LCD items into bus writes.
//
//  channel  dir   payload                                     transaction
//  item     in    mode, byte_value, row, column, number       valid & ready
//  result   out   reg_select, bus_value, last                 valid & ready
//  cfg      in    index (0 nibble mode, 1/2 row bases), value  valid & ready
//
//  Command, data and cursor items run the byte or cursor step, then emit and test.
//  A number runs one divide step per digit, then picks, emits and tests each digit;
//  the step counter walks one control word per cycle unless a stall holds it.
//  Reset zeroes the step counter, result valid and digit count; cfg gets defaults.
//  A result not taken holds the emit step; the item side waits until the program
//  returns to its wait step. The config channel is always ready.
`default_nettype none

module char_lcd_bus_writer (
    input  wire logic clk,
    input  wire logic rst_n,
    clbw_stream_if.sink   item,
    clbw_stream_if.source result,
    clbw_stream_if.sink   cfg
);

    clbw_pkg::clbw_step_t  step_reg, step_next;
    clbw_pkg::clbw_uword_t uw;

    logic        nibble_mode_reg;
    logic [7:0]  row_one_reg;
    logic [7:0]  row_two_reg;

    logic [1:0]  mode_reg, mode_next;
    logic [7:0]  bval_reg, bval_next;
    logic [7:0]  row_reg, row_next;
    logic [7:0]  col_reg, col_next;
    logic [15:0] value_reg, value_next;
    logic [7:0]  byte_reg, byte_next;
    logic        rs_reg, rs_next;
    logic [clbw_pkg::DigitIdxW-1:0] nd_reg, nd_next;
    logic [3:0]  digits_reg [clbw_pkg::NumDigits];
    logic [3:0]  digits_next [clbw_pkg::NumDigits];

    logic                out_valid_reg, out_valid_next;
    clbw_pkg::clbw_out_t out_data_reg, out_data_next;

    logic        stall;
    logic        take;
    logic [31:0] product;
    logic [15:0] quot;
    logic [15:0] quot_x10;
    logic [3:0]  rem;
    logic [7:0]  col_m1;
    logic [7:0]  cursor_cmd;
    logic        slot_free;
    logic        final_byte;
    logic [clbw_pkg::DigitIdxW-1:0] pick_idx;
    clbw_pkg::clbw_step_t dispatch_target;

    assign cfg.ready    = 1'b1;
    assign result.valid = out_valid_reg;
    assign result.data  = out_data_reg;

    // Divide by ten through the reciprocal; exact for all 16-bit values.
    assign product  = {16'd0, value_reg} * 32'(clbw_pkg::DivRecip);
    assign quot     = 16'(product >> clbw_pkg::DivShift);
    assign quot_x10 = (quot << 3) + (quot << 1);
    assign rem      = 4'(value_reg - quot_x10);

    assign col_m1 = col_reg - 8'd1;
    always_comb
    begin
        if (col_reg == 8'd0 || col_reg > clbw_pkg::LastColumn)
            cursor_cmd = row_one_reg;
        else if (row_reg == 8'd1)
            cursor_cmd = row_one_reg + col_m1;
        else if (row_reg == 8'd2)
            cursor_cmd = row_two_reg + col_m1;
        else
            cursor_cmd = row_one_reg;
    end

    assign slot_free  = !out_valid_reg || result.ready;
    assign final_byte = (nd_reg == '0);
    assign pick_idx   = nd_reg - 1'b1;

    always_comb
    begin
        unique case (clbw_pkg::clbw_mode_t'(item.data.mode))
            clbw_pkg::MODE_CMD,
            clbw_pkg::MODE_DATA:   dispatch_target = clbw_pkg::ST_BYTE;
            clbw_pkg::MODE_CURSOR: dispatch_target = clbw_pkg::ST_CURSOR;
            clbw_pkg::MODE_NUMBER: dispatch_target = clbw_pkg::ST_DIV;
            default:               dispatch_target = clbw_pkg::ST_BYTE;
        endcase
    end

    always_comb
    begin
        uw             = clbw_pkg::ucode(step_reg);
        item.ready     = 1'b0;
        stall          = 1'b0;
        mode_next      = mode_reg;
        bval_next      = bval_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        value_next     = value_reg;
        byte_next      = byte_reg;
        rs_next        = rs_reg;
        nd_next        = nd_reg;
        digits_next    = digits_reg;
        out_valid_next = out_valid_reg && !result.ready;
        out_data_next  = out_data_reg;

        unique case (uw.op)
            clbw_pkg::OP_WAIT:
            begin
                item.ready = 1'b1;
                if (item.valid)
                begin
                    mode_next  = item.data.mode;
                    bval_next  = item.data.byte_value;
                    row_next   = item.data.row;
                    col_next   = item.data.column;
                    value_next = item.data.number;
                    nd_next    = '0;
                end
                else
                begin
                    stall = 1'b1;
                end
            end
            clbw_pkg::OP_DIV:
            begin
                digits_next[nd_reg] = rem;
                value_next          = quot;
                nd_next             = nd_reg + 1'b1;
                rs_next             = 1'b1;
            end
            clbw_pkg::OP_PICK:
            begin
                byte_next = clbw_pkg::AsciiZero + {4'd0, digits_reg[pick_idx]};
                nd_next   = pick_idx;
            end
            clbw_pkg::OP_EMIT_HI:
            begin
                if (!slot_free)
                begin
                    stall = 1'b1;
                end
                else
                begin
                    out_valid_next           = 1'b1;
                    out_data_next.reg_select = rs_reg;
                    out_data_next.bus_value  = nibble_mode_reg ? {4'd0, byte_reg[7:4]}
                                                               : byte_reg;
                    out_data_next.last       = !nibble_mode_reg && final_byte;
                end
            end
            clbw_pkg::OP_EMIT_LO:
            begin
                if (!slot_free)
                begin
                    stall = 1'b1;
                end
                else
                begin
                    out_valid_next           = 1'b1;
                    out_data_next.reg_select = rs_reg;
                    out_data_next.bus_value  = {4'd0, byte_reg[3:0]};
                    out_data_next.last       = final_byte;
                end
            end
            clbw_pkg::OP_NOP:
            begin
            end
            clbw_pkg::OP_BYTE:
            begin
                byte_next = bval_reg;
                rs_next   = mode_reg[0];
            end
            clbw_pkg::OP_CURSOR:
            begin
                byte_next = cursor_cmd;
                rs_next   = 1'b0;
            end
            default:
            begin
            end
        endcase

        unique case (uw.cond)
            clbw_pkg::C_NEXT:        take = 1'b0;
            clbw_pkg::C_ALWAYS:      take = 1'b1;
            clbw_pkg::C_DISPATCH:    take = 1'b1;
            clbw_pkg::C_DIV_MORE:    take = (quot != 16'd0);
            clbw_pkg::C_EIGHT_BIT:   take = !nibble_mode_reg;
            clbw_pkg::C_DIGITS_LEFT: take = !final_byte;
            default:                 take = 1'b0;
        endcase

        if (stall)
            step_next = step_reg;
        else if (uw.cond == clbw_pkg::C_DISPATCH)
            step_next = dispatch_target;
        else if (take)
            step_next = uw.target;
        else if (uw.cond == clbw_pkg::C_DIGITS_LEFT || step_reg == clbw_pkg::ST_EMIT_LO)
            step_next = (step_reg == clbw_pkg::ST_EMIT_LO) ? clbw_pkg::ST_TEST
                                                           : clbw_pkg::ST_WAIT;
        else
            step_next = clbw_pkg::clbw_step_t'(step_reg + 3'd1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg        <= clbw_pkg::ST_WAIT;
            out_valid_reg   <= 1'b0;
            nd_reg          <= '0;
            nibble_mode_reg <= 1'b0;
            row_one_reg     <= 8'd128;
            row_two_reg     <= 8'd192;
        end
        else
        begin
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
            nd_reg        <= nd_next;
            if (cfg.valid)
            begin
                unique case (clbw_pkg::clbw_cfg_idx_t'(cfg.data.index))
                    clbw_pkg::CFG_NIBBLE_MODE: nibble_mode_reg <= cfg.data.value[0];
                    clbw_pkg::CFG_ROW_ONE:     row_one_reg     <= cfg.data.value;
                    clbw_pkg::CFG_ROW_TWO:     row_two_reg     <= cfg.data.value;
                    clbw_pkg::CFG_NONE:        ;
                    default:                   ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg     <= mode_next;
        bval_reg     <= bval_next;
        row_reg      <= row_next;
        col_reg      <= col_next;
        value_reg    <= value_next;
        byte_reg     <= byte_next;
        rs_reg       <= rs_next;
        digits_reg   <= digits_next;
        out_data_reg <= out_data_next;
    end

    // No digits may be pending while a new item can be taken.
    a_idle_no_digits: assert property (@(posedge clk) disable iff (!rst_n)
        item.ready |-> (nd_reg == '0))
        else $error("digits pending while waiting for an item");

    // The low-nibble step only runs on a four-bit bus.
    a_lo_nibble_mode: assert property (@(posedge clk) disable iff (!rst_n)
        (step_reg == clbw_pkg::ST_EMIT_LO) |-> nibble_mode_reg)
        else $error("low nibble step on an eight-bit bus");

    // An accepted item leaves the wait step.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (item.valid && item.ready) |=> !item.ready)
        else $error("item side ready right after a transaction");

endmodule

`default_nettype wire
